// ===== sv/iqf_pkg.sv =====
package iqf_pkg;

	// Receiver limits and field widths
	localparam int MAX_RECEIVERS = 8;
	localparam int CNT_W         = 4;
	localparam int SAMPLE_W      = 24;
	localparam int SLOT_W        = 6;
	localparam int RX_W          = 3;
	localparam int PAD_W         = 5;
	localparam int SEQ_W         = 32;

	// Queue between classifier and byte sequencer
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// Fixed header bytes
	localparam logic [7:0] SYNC_B0  = 8'hEF;
	localparam logic [7:0] SYNC_B1  = 8'hFE;
	localparam logic [7:0] SYNC_B2  = 8'h01;
	localparam logic [7:0] SYNC_B3  = 8'h06;
	localparam logic [7:0] HALF_MRK = 8'h7F;

	// Byte counts of the fixed sections
	localparam logic [4:0] SYNC_LEN = 5'd8;
	localparam logic [4:0] HDR_LEN  = 5'd8;
	localparam logic [4:0] IQ_LEN   = 5'd6;
	localparam logic [4:0] MIC_LEN  = 5'd2;

	// One classified sample word, as handed from front to back
	typedef struct packed {
		logic [SAMPLE_W-1:0] i_value;
		logic [SAMPLE_W-1:0] q_value;
		logic                hdr_pkt;   // sync and sequence precede the sample
		logic                hdr_half;  // half header precedes the sample
		logic                slot_end;  // mic bytes follow the sample
		logic                half_end;  // padding follows the mic bytes
		logic                eop;       // last byte of this word closes the packet
		logic [PAD_W-1:0]    pad;
		logic [SEQ_W-1:0]    seq;
	} iqf_desc_t;

	// Register value to receivers in use: zero acts as one, clamp at the maximum
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		begin
			r = c;
			if (c == '0) begin
				r = CNT_W'(1);
			end else if (c > CNT_W'(MAX_RECEIVERS)) begin
				r = CNT_W'(MAX_RECEIVERS);
			end
			return r;
		end
	endfunction

	// Slots per half, floor(504 / (6*count + 2))
	function automatic logic [SLOT_W-1:0] slots_per_half(input logic [CNT_W-1:0] c);
		logic [SLOT_W-1:0] r;
		begin
			case (c)
				4'd1:    r = 6'd63;
				4'd2:    r = 6'd36;
				4'd3:    r = 6'd25;
				4'd4:    r = 6'd19;
				4'd5:    r = 6'd15;
				4'd6:    r = 6'd13;
				4'd7:    r = 6'd11;
				4'd8:    r = 6'd10;
				default: r = 6'd63;
			endcase
			return r;
		end
	endfunction

	// Zero bytes that fill each half after its last slot
	function automatic logic [PAD_W-1:0] pad_per_half(input logic [CNT_W-1:0] c);
		logic [PAD_W-1:0] r;
		begin
			case (c)
				4'd1:    r = 5'd0;
				4'd2:    r = 5'd0;
				4'd3:    r = 5'd4;
				4'd4:    r = 5'd10;
				4'd5:    r = 5'd24;
				4'd6:    r = 5'd10;
				4'd7:    r = 5'd20;
				4'd8:    r = 5'd4;
				default: r = 5'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== sv/iqf_if.sv =====
// Sample channel: one I/Q pair per word
interface iqf_iq_if import iqf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] i_value;
	logic signed [SAMPLE_W-1:0] q_value;

	modport source (output valid, output i_value, output q_value, input ready);
	modport sink   (input valid, input i_value, input q_value, output ready);
endinterface

// Packet channel: one byte per word
interface iqf_pkt_if ();
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       end_of_packet;

	modport source (output valid, output packet_byte, output end_of_packet, input ready);
	modport sink   (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

// ===== sv/iqf_front.sv =====
module iqf_front import iqf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	iqf_iq_if.sink           iq,
	input  logic             q_full,
	output logic             q_push,
	output iqf_desc_t        q_desc
);

	logic [CNT_W-1:0]  receiver_count_q;
	logic [CNT_W-1:0]  active_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              half_q;
	logic [SLOT_W-1:0] slot_q;
	logic [RX_W-1:0]   rx_q;

	logic              first;
	logic [CNT_W-1:0]  cnt;
	logic              slot_end;
	logic              half_end;

	// Classify the incoming word against the frame position
	always_comb begin
		first    = (slot_q == '0) && (rx_q == '0);
		cnt      = first ? eff_count(receiver_count_q) : active_q;
		slot_end = ({1'b0, rx_q} + CNT_W'(1)) == cnt;
		half_end = slot_end && (({1'b0, slot_q} + 7'd1) == {1'b0, slots_per_half(cnt)});
	end

	assign iq.ready = !q_full;
	assign q_push   = iq.valid && !q_full;

	always_comb begin
		q_desc.i_value  = iq.i_value;
		q_desc.q_value  = iq.q_value;
		q_desc.hdr_pkt  = first && !half_q;
		q_desc.hdr_half = first;
		q_desc.slot_end = slot_end;
		q_desc.half_end = half_end;
		q_desc.eop      = half_end && half_q;
		q_desc.pad      = pad_per_half(cnt);
		q_desc.seq      = seq_q;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiver_count_q <= CNT_W'(1);
		end else if (cfg_wr_en) begin
			receiver_count_q <= cfg_wr_data;
		end
	end

	// Frame position, advanced per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(1);
			seq_q    <= '0;
			half_q   <= 1'b0;
			slot_q   <= '0;
			rx_q     <= '0;
		end else if (q_push) begin
			active_q <= cnt;
			if (slot_end) begin
				rx_q <= '0;
			end else begin
				rx_q <= rx_q + RX_W'(1);
			end
			if (half_end) begin
				slot_q <= '0;
				half_q <= !half_q;
				if (half_q) begin
					seq_q <= seq_q + SEQ_W'(1);
				end
			end else if (slot_end) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

endmodule

// ===== sv/iqf_fifo.sv =====
module iqf_fifo import iqf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  iqf_desc_t push_data,
	output logic      full,
	input  logic      pop,
	output iqf_desc_t pop_data,
	output logic      not_empty
);

	iqf_desc_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   count_q;

	assign full      = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue level beyond depth");
`endif

endmodule

// ===== sv/iqf_back.sv =====
module iqf_back import iqf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_not_empty,
	input  iqf_desc_t q_desc,
	output logic      q_pop,
	iqf_pkt_if.source pkt
);

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_SYNC = 6'b000010,
		PH_HDR  = 6'b000100,
		PH_IQ   = 6'b001000,
		PH_MIC  = 6'b010000,
		PH_PAD  = 6'b100000
	} phase_t;

	phase_t     ph_q, ph_next, ph_first;
	logic [4:0] cnt_q;
	iqf_desc_t  cur_q;
	logic [7:0] byte_q, byte_d;
	logic       eop_q;
	logic       out_valid_q;
	logic       advance;
	logic       done;

	assign advance = !out_valid_q || pkt.ready;

	// First section of the next word
	always_comb begin
		if (q_desc.hdr_pkt) begin
			ph_first = PH_SYNC;
		end else if (q_desc.hdr_half) begin
			ph_first = PH_HDR;
		end else begin
			ph_first = PH_IQ;
		end
	end

	// Byte of the current section and the section that follows it
	always_comb begin
		byte_d  = 8'h00;
		ph_next = ph_q;
		done    = 1'b0;
		case (ph_q)
			PH_SYNC: begin
				case (cnt_q[2:0])
					3'd0:    byte_d = SYNC_B0;
					3'd1:    byte_d = SYNC_B1;
					3'd2:    byte_d = SYNC_B2;
					3'd3:    byte_d = SYNC_B3;
					3'd4:    byte_d = cur_q.seq[31:24];
					3'd5:    byte_d = cur_q.seq[23:16];
					3'd6:    byte_d = cur_q.seq[15:8];
					default: byte_d = cur_q.seq[7:0];
				endcase
				if (cnt_q == SYNC_LEN - 5'd1) begin
					ph_next = PH_HDR;
				end
			end
			PH_HDR: begin
				byte_d = (cnt_q < 5'd3) ? HALF_MRK : 8'h00;
				if (cnt_q == HDR_LEN - 5'd1) begin
					ph_next = PH_IQ;
				end
			end
			PH_IQ: begin
				case (cnt_q[2:0])
					3'd0:    byte_d = cur_q.i_value[23:16];
					3'd1:    byte_d = cur_q.i_value[15:8];
					3'd2:    byte_d = cur_q.i_value[7:0];
					3'd3:    byte_d = cur_q.q_value[23:16];
					3'd4:    byte_d = cur_q.q_value[15:8];
					default: byte_d = cur_q.q_value[7:0];
				endcase
				if (cnt_q == IQ_LEN - 5'd1) begin
					if (cur_q.slot_end) begin
						ph_next = PH_MIC;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_MIC: begin
				if (cnt_q == MIC_LEN - 5'd1) begin
					if (cur_q.half_end && cur_q.pad != '0) begin
						ph_next = PH_PAD;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_PAD: begin
				if (cnt_q + 5'd1 == cur_q.pad) begin
					done = 1'b1;
				end
			end
			default: begin
				byte_d = 8'h00;
			end
		endcase
	end

	assign q_pop = q_not_empty && ((ph_q == PH_IDLE) || (advance && done));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			cnt_q <= '0;
		end else if (q_pop) begin
			ph_q  <= ph_first;
			cnt_q <= '0;
		end else if (advance && ph_q != PH_IDLE) begin
			if (done) begin
				ph_q  <= PH_IDLE;
				cnt_q <= '0;
			end else if (ph_next != ph_q) begin
				ph_q  <= ph_next;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	// Current word
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ph_q != PH_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ph_q != PH_IDLE) begin
			byte_q <= byte_d;
			eop_q  <= done && cur_q.eop;
		end
	end

	assign pkt.valid         = out_valid_q;
	assign pkt.packet_byte   = byte_q;
	assign pkt.end_of_packet = eop_q;

`ifndef SYNTHESIS
	a_pad_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_PAD |-> cur_q.half_end && cnt_q < cur_q.pad)
		else $error("padding outside a half end");
	a_sync_has_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_SYNC |-> cur_q.hdr_half)
		else $error("packet header without half header");
	a_iq_count: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_IQ |-> cnt_q < IQ_LEN)
		else $error("sample byte count overrun");
`endif

endmodule

// ===== sv/iq_sample_packet_framer_core.sv =====
// Channel  Dir  Payload                         Handshake
// iq       in   i_value[23:0], q_value[23:0]    iq.valid / iq.ready
// pkt      out  packet_byte[7:0], end_of_packet pkt.valid / pkt.ready
// cfg      in   cfg_wr_data[3:0] (receiver_count) cfg_wr_en, no wait
//
// One packet byte leaves per cycle while pkt.ready is high and the queue holds words; a sample
// word gives 6 bytes, plus 8 for a half header, 8 more for a packet header, 2 mic bytes at slot
// end and up to 24 bytes of padding at half end. The byte sequencer sets the pace; a 4-word queue
// lets the input run ahead of it, and when it runs dry the sequencer idles until the next word.
// Reset clears the frame position, sequence number, queue and output register; no memory sweep.
// pkt.ready low holds the output byte and stalls the sequencer; iq.ready drops on a full queue.
module iq_sample_packet_framer_core import iqf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	iqf_iq_if.sink           iq,
	iqf_pkt_if.source        pkt
);

	iqf_desc_t push_desc;
	iqf_desc_t pop_desc;
	logic      push;
	logic      pop;
	logic      full;
	logic      not_empty;

	// Classifier
	iqf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.iq          (iq),
		.q_full      (full),
		.q_push      (push),
		.q_desc      (push_desc)
	);

	// Word queue
	iqf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_desc),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_desc),
		.not_empty (not_empty)
	);

	// Byte sequencer
	iqf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.q_desc      (pop_desc),
		.q_pop       (pop),
		.pkt         (pkt)
	);

endmodule
